[hw/rtl/amc_pkg.sv]
// shared types, codes and defaults for the adjacency matrix connectivity block
package amc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 32;
    localparam int VFIELD_W         = 6;
    localparam int WFIELD_W         = 32;
    localparam int KIND_W           = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int VCOUNT_W         = 7;

    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REACH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE    = 2'd2;

    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        ADDR_AB,
        ADDR_BA,
        ADDR_UV,
        ADDR_SWEEP
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_ITEM,
        WD_EMPTY,
        WD_ZERO
    } wdata_sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_ISSUE,
        ST_RD_CHECK,
        ST_WR_AB,
        ST_WR_BA,
        ST_CLEAR,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_LOADU,
        ST_BFS_READ,
        ST_BFS_CHECK,
        ST_DONE
    } amc_state_t;

    typedef struct packed {
        logic       load_item;
        logic       mem_we;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       sweep_clr;
        logic       sweep_inc;
        logic       bfs_init;
        logic       q_pop;
        logic       u_load;
        logic       bfs_check;
        logic       cap_get;
        logic       cap_conn;
        logic       set_changed;
        logic       out_load;
    } amc_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              inr;
        logic              rd_differs;
        logic              scan_last;
        logic              queue_empty;
        logic              sweep_last;
        logic              out_free;
    } amc_status_t;

endpackage

[hw/rtl/amc_ram.sv]
// generic single-write, single-read ram with registered read data
module amc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/amc_datapath.sv]
// matrix storage, breadth-first search queue, config registers and result register
module amc_datapath #(
    parameter int MAX_VERTICES = amc_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = amc_pkg::WEIGHT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  amc_pkg::amc_cmd_t                cmd,
    output amc_pkg::amc_status_t             status,
    input  logic [amc_pkg::KIND_W-1:0]       in_kind,
    input  logic [amc_pkg::VFIELD_W-1:0]     in_first,
    input  logic [amc_pkg::VFIELD_W-1:0]     in_second,
    input  logic [amc_pkg::WFIELD_W-1:0]     in_weight,
    input  logic                             cfg_we,
    input  logic [amc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [amc_pkg::WFIELD_W-1:0]     cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [amc_pkg::WFIELD_W-1:0]     out_weight,
    output logic                             out_present,
    output logic                             out_connected,
    output logic                             out_in_range,
    output logic                             out_changed
);
    import amc_pkg::*;

    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = WEIGHT_BITS;

    logic [KIND_W-1:0]   kind_reg;
    logic [VFIELD_W-1:0] a_reg, b_reg;
    logic [WB-1:0]       w_reg;
    logic                wm_reg;
    logic [VCOUNT_W-1:0] vc_reg;
    logic [WB-1:0]       ec_reg;
    logic [AW-1:0]       sweep_reg;
    logic [NW-1:0]       head_reg, tail_reg, v_reg;
    logic [VW-1:0]       u_reg;
    logic [MAX_VERTICES-1:0] seen_reg;
    logic                out_valid_reg;
    logic [WFIELD_W-1:0] res_weight_reg;
    logic                res_present_reg, res_conn_reg, res_changed_reg;
    logic [WFIELD_W-1:0] out_weight_reg;
    logic                out_present_reg, out_conn_reg, out_inr_reg, out_changed_reg;

    logic [NW-1:0]  live_n;
    logic [WB-1:0]  empty_w, w_store, mem_rdata, mem_wdata;
    logic [AW-1:0]  mem_addr;
    logic [VW-1:0]  av, bv, vv;
    logic           inr, hit;
    logic           q_we;
    logic [VW-1:0]  q_waddr, q_wdata, q_rdata;

    assign live_n  = (32'(vc_reg) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_reg);
    assign empty_w = wm_reg ? ec_reg : '0;
    assign w_store = (!wm_reg && w_reg != '0) ? WB'(1) : w_reg;
    assign av      = VW'(a_reg);
    assign bv      = VW'(b_reg);
    assign vv      = v_reg[VW-1:0];
    assign inr     = (32'(a_reg) < 32'(live_n)) && (32'(b_reg) < 32'(live_n));
    assign hit     = (mem_rdata != empty_w) && !seen_reg[vv];

    always_comb begin
        unique case (cmd.addr_sel)
            ADDR_AB:    mem_addr = AW'(AW'(av) * AW'(MAX_VERTICES) + AW'(bv));
            ADDR_BA:    mem_addr = AW'(AW'(bv) * AW'(MAX_VERTICES) + AW'(av));
            ADDR_UV:    mem_addr = AW'(AW'(u_reg) * AW'(MAX_VERTICES) + AW'(vv));
            ADDR_SWEEP: mem_addr = sweep_reg;
            default:    mem_addr = sweep_reg;
        endcase
        unique case (cmd.wdata_sel)
            WD_ITEM:  mem_wdata = w_store;
            WD_EMPTY: mem_wdata = empty_w;
            default:  mem_wdata = '0;
        endcase
    end

    amc_ram #(.WIDTH(WB), .DEPTH(DEPTH)) u_matrix (
        .aclk  (aclk),
        .we    (cmd.mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // search queue: start vertex at slot zero, newly reached vertices at the tail
    assign q_we    = cmd.bfs_init || (cmd.bfs_check && hit);
    assign q_waddr = cmd.bfs_init ? '0 : tail_reg[VW-1:0];
    assign q_wdata = cmd.bfs_init ? av : vv;

    amc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[VW-1:0]),
        .rdata (q_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= in_kind;
            a_reg    <= in_first;
            b_reg    <= in_second;
            w_reg    <= WB'(in_weight);
        end
        if (cmd.u_load) begin
            u_reg <= q_rdata;
        end
        if (cmd.load_item) begin
            res_weight_reg  <= '0;
            res_present_reg <= 1'b0;
            res_conn_reg    <= 1'b0;
            res_changed_reg <= 1'b0;
        end else begin
            if (cmd.cap_get) begin
                res_weight_reg  <= inr ? WFIELD_W'($signed(mem_rdata))
                                       : WFIELD_W'($signed(empty_w));
                res_present_reg <= inr && (mem_rdata != empty_w);
            end
            if (cmd.cap_conn) begin
                res_conn_reg <= seen_reg[bv];
            end
            if (cmd.set_changed) begin
                res_changed_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_weight_reg  <= res_weight_reg;
            out_present_reg <= res_present_reg;
            out_conn_reg    <= res_conn_reg;
            out_inr_reg     <= inr;
            out_changed_reg <= res_changed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm_reg        <= 1'b0;
            vc_reg        <= VERTEX_COUNT_RST;
            ec_reg        <= WB'(32'h8000_0000);
            sweep_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            v_reg         <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_WEIGHTED_MODE: wm_reg <= cfg_data[0];
                    CFG_VERTEX_COUNT:  vc_reg <= cfg_data[VCOUNT_W-1:0];
                    CFG_EMPTY_CODE:    ec_reg <= WB'(cfg_data);
                    default:           ;
                endcase
            end
            if (cmd.sweep_clr) begin
                sweep_reg <= '0;
            end else if (cmd.sweep_inc) begin
                sweep_reg <= AW'(sweep_reg + 1'b1);
            end
            if (cmd.bfs_init) begin
                seen_reg <= MAX_VERTICES'(1) << av;
                head_reg <= '0;
                tail_reg <= NW'(1);
            end else begin
                if (cmd.q_pop) begin
                    head_reg <= NW'(head_reg + 1'b1);
                end
                if (cmd.bfs_check && hit) begin
                    seen_reg[vv] <= 1'b1;
                    tail_reg     <= NW'(tail_reg + 1'b1);
                end
            end
            if (cmd.u_load) begin
                v_reg <= '0;
            end else if (cmd.bfs_check) begin
                v_reg <= NW'(v_reg + 1'b1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.kind        = kind_reg;
    assign status.inr         = inr;
    assign status.rd_differs  = (mem_rdata != w_reg);
    assign status.scan_last   = (NW'(v_reg + 1'b1) == live_n);
    assign status.queue_empty = (head_reg == tail_reg);
    assign status.sweep_last  = (32'(sweep_reg) == DEPTH - 1);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_weight    = out_weight_reg;
    assign out_present   = out_present_reg;
    assign out_connected = out_conn_reg;
    assign out_in_range  = out_inr_reg;
    assign out_changed   = out_changed_reg;

endmodule

[hw/rtl/amc_ctrl.sv]
// controller state machine sequencing matrix accesses, sweeps and searches
module amc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  amc_pkg::amc_status_t status,
    output amc_pkg::amc_cmd_t    cmd
);
    import amc_pkg::*;

    amc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:      if (status.sweep_last) state_next = ST_IDLE;
            ST_IDLE:      if (in_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                case (status.kind)
                    KIND_ADD, KIND_GET: state_next = status.inr ? ST_RD_ISSUE : ST_DONE;
                    KIND_DEL:   state_next = status.inr ? ST_WR_AB : ST_DONE;
                    KIND_REACH: state_next = status.inr ? ST_BFS_INIT : ST_DONE;
                    KIND_CLEAR: state_next = ST_CLEAR;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_RD_ISSUE:  state_next = ST_RD_CHECK;
            ST_RD_CHECK: begin
                if (status.kind == KIND_ADD && status.rd_differs) state_next = ST_WR_AB;
                else state_next = ST_DONE;
            end
            ST_WR_AB:     state_next = ST_WR_BA;
            ST_WR_BA:     state_next = ST_DONE;
            ST_CLEAR:     if (status.sweep_last) state_next = ST_DONE;
            ST_BFS_INIT:  state_next = ST_BFS_POP;
            ST_BFS_POP:   state_next = status.queue_empty ? ST_DONE : ST_BFS_LOADU;
            ST_BFS_LOADU: state_next = ST_BFS_READ;
            ST_BFS_READ:  state_next = ST_BFS_CHECK;
            ST_BFS_CHECK: state_next = status.scan_last ? ST_BFS_POP : ST_BFS_READ;
            ST_DONE:      if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.addr_sel = ADDR_AB;
        cmd.wdata_sel = WD_ITEM;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = ADDR_SWEEP;
                cmd.wdata_sel = WD_ZERO;
                cmd.sweep_inc = 1'b1;
            end
            ST_IDLE: begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_DISPATCH: begin
                cmd.sweep_clr = 1'b1;
                // out of range get reports the empty value
                cmd.cap_get   = (status.kind == KIND_GET);
            end
            ST_RD_CHECK: begin
                cmd.cap_get = (status.kind == KIND_GET);
            end
            ST_WR_AB, ST_WR_BA: begin
                cmd.mem_we      = 1'b1;
                cmd.addr_sel    = (state_reg == ST_WR_AB) ? ADDR_AB : ADDR_BA;
                cmd.wdata_sel   = (status.kind == KIND_DEL) ? WD_EMPTY : WD_ITEM;
                cmd.set_changed = 1'b1;
            end
            ST_CLEAR: begin
                cmd.mem_we      = 1'b1;
                cmd.addr_sel    = ADDR_SWEEP;
                cmd.wdata_sel   = WD_EMPTY;
                cmd.sweep_inc   = 1'b1;
                cmd.set_changed = 1'b1;
            end
            ST_BFS_INIT:  cmd.bfs_init = 1'b1;
            ST_BFS_POP: begin
                cmd.q_pop    = !status.queue_empty;
                cmd.cap_conn = status.queue_empty;
            end
            ST_BFS_LOADU: cmd.u_load = 1'b1;
            ST_BFS_READ:  cmd.addr_sel = ADDR_UV;
            ST_BFS_CHECK: begin
                cmd.addr_sel  = ADDR_UV;
                cmd.bfs_check = 1'b1;
            end
            ST_DONE:      cmd.out_load = status.out_free;
            default:      ;
        endcase
    end

endmodule

[hw/rtl/adjacency_matrix_connectivity.sv]
// Undirected graph store with connectivity queries. The weight matrix sits in one
// single-port-style ram, so after reset the block first runs a clearing pass of
// MAX_VERTICES*MAX_VERTICES entries with s_tready low (config writes still taken).
// One request is worked at a time. Clear sweeps the whole matrix, one entry per
// cycle. Reachable runs a breadth-first search from the first vertex, reading each
// matrix entry and checking it before it reads the next. The result register frees
// the input side while a result waits.
module adjacency_matrix_connectivity
    import amc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_vertex[5:0], second_vertex[11:6], edge_weight[43:12], zero pad
    input  logic [47:0]          s_tdata,
    // kind[2:0]
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // weight_out[31:0], edge_present[32], connected[33], in_range[34],
    // changed[35], zero pad
    output logic [39:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WFIELD_W-1:0]  cfg_data
);

    amc_cmd_t    ctl_cmd;
    amc_status_t dp_status;
    logic [WFIELD_W-1:0] res_weight;
    logic res_present, res_conn, res_inr, res_changed;

    assign cfg_ready = 1'b1;

    amc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    amc_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (ctl_cmd),
        .status        (dp_status),
        .in_kind       (s_tuser),
        .in_first      (s_tdata[5:0]),
        .in_second     (s_tdata[11:6]),
        .in_weight     (s_tdata[43:12]),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_weight    (res_weight),
        .out_present   (res_present),
        .out_connected (res_conn),
        .out_in_range  (res_inr),
        .out_changed   (res_changed)
    );

    assign m_tdata = {4'b0, res_changed, res_inr, res_conn, res_present, res_weight};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in work");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.out_load |-> dp_status.out_free)
        else $error("result register overwritten");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.mem_we |-> !s_tready)
        else $error("matrix written while idle");
`endif

endmodule

[tb/adjacency_matrix_connectivity_tb.sv]
// testbench for the adjacency matrix connectivity block: directed, stall and random requests
module adjacency_matrix_connectivity_tb;
    import amc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = MAX_VERTICES_DEF;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

    typedef struct {
        logic [31:0] weight;
        logic        present;
        logic        linked;
        logic        inr;
        logic        wrote;
    } answer_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // first_vertex[5:0], second_vertex[11:6], edge_weight[43:12], zero pad
    logic [47:0]          s_tdata = '0;
    // kind[2:0]
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // weight_out[31:0], edge_present[32], connected[33], in_range[34], changed[35], zero pad
    logic [39:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WFIELD_W-1:0]  cfg_data = '0;

    adjacency_matrix_connectivity dut (.*);

    always #5 aclk = ~aclk;

    // graph mirror
    logic [31:0]         adj [NV][NV];
    logic                weighted;
    logic [VCOUNT_W-1:0] vcount;
    logic [31:0]         empty_code;

    answer_t answers_due [$];
    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    int  linked_hits = 0;
    bit  idle_en = 1'b1;
    int  hold_req = 0;
    int  hold_cnt = 0;
    int  rx_gap = 0;
    int  quiet_cycles = 0;

    function automatic int live_n();
        return (vcount > NV) ? NV : int'(vcount);
    endfunction

    function automatic logic [31:0] empty_now();
        return weighted ? empty_code : 32'd0;
    endfunction

    // breadth-first walk from a over live vertices
    function automatic bit joined(int a, int b);
        bit seen [NV];
        int fifo [NV];
        int head, tail, u, n;
        logic [31:0] e;
        n = live_n();
        e = empty_now();
        foreach (seen[i]) seen[i] = 1'b0;
        head = 0;
        tail = 1;
        fifo[0] = a;
        seen[a] = 1'b1;
        while (head < tail) begin
            u = fifo[head];
            head++;
            for (int v = 0; v < n; v++) begin
                if (!seen[v] && adj[u][v] != e) begin
                    seen[v] = 1'b1;
                    fifo[tail] = v;
                    tail++;
                end
            end
        end
        return seen[b];
    endfunction

    function automatic answer_t apply_request(logic [KIND_W-1:0] kind, int a, int b,
                                              logic [31:0] w);
        answer_t r;
        logic [31:0] e;
        e = empty_now();
        r = '{32'd0, 1'b0, 1'b0, 1'b0, 1'b0};
        r.inr = (a < live_n()) && (b < live_n());
        case (kind)
            KIND_ADD: begin
                if (r.inr && adj[a][b] != w) begin
                    if (!weighted && w != 0) w = 32'd1;
                    adj[a][b] = w;
                    adj[b][a] = w;
                    r.wrote = 1'b1;
                end
            end
            KIND_DEL: begin
                if (r.inr) begin
                    adj[a][b] = e;
                    adj[b][a] = e;
                    r.wrote = 1'b1;
                end
            end
            KIND_GET: begin
                if (r.inr) begin
                    r.weight = adj[a][b];
                    r.present = adj[a][b] != e;
                end else begin
                    r.weight = e;
                end
            end
            KIND_REACH: begin
                if (r.inr) r.linked = joined(a, b);
            end
            KIND_CLEAR: begin
                foreach (adj[i, j]) adj[i][j] = e;
                r.wrote = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    endtask

    task automatic send_request(logic [KIND_W-1:0] kind, int a, int b, logic [31:0] w);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'd0, w, 6'(b), 6'(a)};
        do @(posedge aclk); while (!s_tready);
        answers_due.push_back(apply_request(kind, a, b, w));
        if (kind == KIND_REACH && answers_due[$].linked) linked_hits++;
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WEIGHTED_MODE: weighted = value[0];
            CFG_VERTEX_COUNT:  vcount = value[VCOUNT_W-1:0];
            CFG_EMPTY_CODE:    empty_code = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(bit wm, int vc, logic [31:0] code);
        drain();
        write_reg(CFG_WEIGHTED_MODE, 32'(wm));
        write_reg(CFG_VERTEX_COUNT, 32'(vc));
        write_reg(CFG_EMPTY_CODE, code);
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return empty_now();
            1: return 32'd0;
            2: return 32'd1;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0000;
            5: return 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(int span, bit allow_clear);
        logic [KIND_W-1:0] kind;
        int roll, a, b;
        roll = $urandom_range(0, 99);
        if (roll < 38) kind = KIND_ADD;
        else if (roll < 52) kind = KIND_DEL;
        else if (roll < 72) kind = KIND_GET;
        else if (roll < 96) kind = KIND_REACH;
        else if (roll < 98) kind = allow_clear ? KIND_CLEAR : KIND_GET;
        else kind = KIND_W'($urandom_range(5, 7));
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
        b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
        send_request(kind, a, b, pick_weight());
    endtask

    task automatic test_directed();
        send_request(KIND_ADD, 0, 63, 32'h7fff_ffff);
        send_request(KIND_ADD, 63, 0, 32'h8000_0000);
        send_request(KIND_ADD, 5, 6, 32'd0);
        send_request(KIND_GET, 63, 0, 32'd0);
        send_request(KIND_REACH, 0, 63, 32'd0);
        send_request(KIND_REACH, 0, 1, 32'd0);
        send_request(KIND_REACH, 7, 7, 32'd0);
        send_request(KIND_DEL, 0, 63, 32'd0);
        send_request(KIND_GET, 0, 63, 32'd0);
        send_request(KIND_RSVD5, 1, 2, 32'hffff_ffff);
        send_request(KIND_RSVD6, 63, 63, 32'd0);
        send_request(KIND_RSVD7, 0, 0, 32'd0);
        send_request(KIND_CLEAR, 0, 0, 32'd0);
        // no vertices in use: everything out of range
        setup(1'b1, 0, 32'h8000_0000);
        send_request(KIND_ADD, 0, 0, 32'd9);
        send_request(KIND_GET, 0, 0, 32'd0);
        send_request(KIND_REACH, 0, 0, 32'd0);
        send_request(KIND_DEL, 0, 0, 32'd0);
        // counts above the matrix size clamp; stale bits read under new empty code
        setup(1'b1, 127, 32'h7fff_ffff);
        send_request(KIND_ADD, 2, 3, 32'h7fff_ffff);
        send_request(KIND_GET, 2, 3, 32'd0);
        send_request(KIND_REACH, 2, 3, 32'd0);
        send_request(KIND_ADD, 2, 3, 32'hffff_fff6);
        send_request(KIND_REACH, 3, 2, 32'd0);
        send_request(KIND_GET, 1, 63, 32'd0);
    endtask

    task automatic test_backpressure();
        setup(1'b0, 8, $urandom);
        @(posedge aclk);
        hold_req = 300;
        @(negedge aclk);
        repeat (20) random_request(8, 1'b0);
        // sender waits for all answers before the next burst
        drain();
        repeat (20) random_request(8, 1'b0);
    endtask

    task automatic test_random(int phases, int per_phase);
        int vc;
        logic [31:0] code;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 9))
                0: vc = 64;
                1: vc = $urandom_range(65, 127);
                2: vc = $urandom_range(0, 2);
                default: vc = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 4))
                0: code = 32'h8000_0000;
                1: code = 32'h7fff_ffff;
                2: code = 32'd0;
                3: code = 32'hffff_ffff;
                default: code = $urandom;
            endcase
            setup($urandom_range(0, 1), vc, code);
            if (p % 4 == 0) send_request(KIND_CLEAR, 0, 0, 32'd0);
            repeat (per_phase) random_request((vc > 12) ? 12 : ((vc < 2) ? 2 : vc), 1'b0);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                errors++;
                $display("unexpected result at %0t: %h", $realtime, m_tdata);
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[31:0] !== want.weight)
                    report("weight_out", m_tdata[31:0], want.weight);
                if (m_tdata[32] !== want.present)
                    report("edge_present", 32'(m_tdata[32]), 32'(want.present));
                if (m_tdata[33] !== want.linked)
                    report("connected", 32'(m_tdata[33]), 32'(want.linked));
                if (m_tdata[34] !== want.inr)
                    report("in_range", 32'(m_tdata[34]), 32'(want.inr));
                if (m_tdata[35] !== want.wrote)
                    report("changed", 32'(m_tdata[35]), 32'(want.wrote));
            end
        end
    end

    // receiver readiness
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 5) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        foreach (adj[i, j]) adj[i][j] = 32'd0;
        weighted = 1'b0;
        vcount = VERTEX_COUNT_RST;
        empty_code = 32'h8000_0000;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(18, 45);
        setup(1'b1, 64, 32'hffff_ffff);
        repeat (40) random_request(64, 1'b0);
        idle_en = 1'b0;
        test_random(2, 40);
        drain();
        $display("covered %0d requests, %0d results, %0d register writes", items_sent,
                 results_seen, reg_writes);
        $display("reachable queries that found a path: %0d", linked_hits);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
